[rtl/udp_spc_pkg.sv]
package udp_spc_pkg;

    // Width of the saturating frame counters
    localparam int COUNT_WIDTH = 32;

    // Register indexes on the configuration port
    localparam logic [7:0] REG_SAMPLE_PORT = 8'd0;
    localparam logic [7:0] REG_FIRST_ID    = 8'd1;
    localparam logic [7:0] REG_SECOND_ID   = 8'd2;

    // Register reset values
    localparam logic [15:0] SAMPLE_PORT_RESET = 16'd6343;
    localparam logic [31:0] FIRST_ID_RESET    = 32'd1;
    localparam logic [31:0] SECOND_ID_RESET   = 32'd2;

    // Protocol constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Classification result codes, in check order
    typedef enum logic [3:0] {
        ST_SHORT_ETH     = 4'd0,
        ST_NOT_IPV4      = 4'd1,
        ST_SHORT_IP      = 4'd2,
        ST_NOT_UDP       = 4'd3,
        ST_SHORT_UDP     = 4'd4,
        ST_WRONG_PORT    = 4'd5,
        ST_SHORT_PAYLOAD = 4'd6,
        ST_AGENT_ONE     = 4'd7,
        ST_AGENT_TWO     = 4'd8,
        ST_AGENT_UNKNOWN = 4'd9
    } status_t;

    // Frame fields as seen after the current byte
    typedef struct packed {
        logic [15:0] len;
        logic [15:0] ether_kind;
        logic [3:0]  header_words;
        logic [7:0]  ip_protocol;
        logic [15:0] dest_port;
        logic [31:0] agent_capture;
    } frame_view_t;

    // Clamp a counter to the 32-bit output field
    function automatic logic [31:0] clamp32(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+31:0] wide;
        logic [COUNT_WIDTH+31:0] lim;
        wide = {32'd0, c};
        lim  = {{COUNT_WIDTH{1'b0}}, 32'hFFFF_FFFF};
        if (wide > lim)
        begin
            return 32'hFFFF_FFFF;
        end
        return wide[31:0];
    endfunction

endpackage

[rtl/udp_spc_frame.sv]
module udp_spc_frame
    import udp_spc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output frame_view_t view
);

    logic [15:0] byte_offset_reg;
    logic [15:0] ether_kind_reg;
    logic [3:0]  header_words_reg;
    logic [7:0]  ip_protocol_reg;
    logic [15:0] dest_port_reg;
    logic [31:0] agent_capture_reg;

    logic [15:0] hl4;
    logic [15:0] port_hi_pos;
    logic [15:0] agent_lo_pos;
    logic [15:0] agent_hi_pos;

    // Positions that follow the IP header length
    assign hl4          = {10'd0, header_words_reg, 2'b00};
    assign port_hi_pos  = 16'd16 + hl4;
    assign agent_lo_pos = 16'd34 + hl4;
    assign agent_hi_pos = 16'd37 + hl4;

    // Capture the current byte into the frame fields
    always_comb
    begin
        view.ether_kind    = ether_kind_reg;
        view.header_words  = header_words_reg;
        view.ip_protocol   = ip_protocol_reg;
        view.dest_port     = dest_port_reg;
        view.agent_capture = agent_capture_reg;
        if (byte_offset_reg == 16'd12)
        begin
            view.ether_kind[15:8] = data_byte;
        end
        if (byte_offset_reg == 16'd13)
        begin
            view.ether_kind[7:0] = data_byte;
        end
        if (byte_offset_reg == 16'd14)
        begin
            view.header_words = data_byte[3:0];
        end
        if (byte_offset_reg == 16'd23)
        begin
            view.ip_protocol = data_byte;
        end
        if (byte_offset_reg == port_hi_pos)
        begin
            view.dest_port[15:8] = data_byte;
        end
        if (byte_offset_reg == port_hi_pos + 16'd1)
        begin
            view.dest_port[7:0] = data_byte;
        end
        if (byte_offset_reg >= agent_lo_pos && byte_offset_reg <= agent_hi_pos)
        begin
            view.agent_capture = {agent_capture_reg[23:0], data_byte};
        end
        // Frame length so far, saturating
        view.len = (byte_offset_reg == 16'hFFFF) ? 16'hFFFF : byte_offset_reg + 16'd1;
    end

    // Hold the fields; clear them after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg   <= '0;
            ether_kind_reg    <= '0;
            header_words_reg  <= '0;
            ip_protocol_reg   <= '0;
            dest_port_reg     <= '0;
            agent_capture_reg <= '0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                byte_offset_reg   <= '0;
                ether_kind_reg    <= '0;
                header_words_reg  <= '0;
                ip_protocol_reg   <= '0;
                dest_port_reg     <= '0;
                agent_capture_reg <= '0;
            end
            else
            begin
                byte_offset_reg   <= view.len;
                ether_kind_reg    <= view.ether_kind;
                header_words_reg  <= view.header_words;
                ip_protocol_reg   <= view.ip_protocol;
                dest_port_reg     <= view.dest_port;
                agent_capture_reg <= view.agent_capture;
            end
        end
    end

endmodule

[rtl/udp_spc_classify.sv]
module udp_spc_classify
    import udp_spc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  frame_view_t view,
    input  logic [15:0] sample_port,
    input  logic [31:0] first_agent_id,
    input  logic [31:0] second_agent_id,
    output status_t     status,
    output logic [31:0] agent_id,
    output logic [31:0] first_count,
    output logic [31:0] second_count
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] first_total_reg;
    logic [COUNT_WIDTH-1:0] second_total_reg;
    logic [COUNT_WIDTH-1:0] first_total_next;
    logic [COUNT_WIDTH-1:0] second_total_next;
    logic [15:0]            hl4;

    assign hl4 = {10'd0, view.header_words, 2'b00};

    // Check the frame in order; the first failing check wins
    always_comb
    begin
        if (view.len < 16'd14)
        begin
            status = ST_SHORT_ETH;
        end
        else if (view.ether_kind != ETHERTYPE_IPV4)
        begin
            status = ST_NOT_IPV4;
        end
        else if (view.len < 16'd34)
        begin
            status = ST_SHORT_IP;
        end
        else if (view.ip_protocol != PROTO_UDP)
        begin
            status = ST_NOT_UDP;
        end
        else if (view.len < 16'd22 + hl4)
        begin
            status = ST_SHORT_UDP;
        end
        else if (view.dest_port != sample_port)
        begin
            status = ST_WRONG_PORT;
        end
        else if (view.len < 16'd130 + hl4)
        begin
            status = ST_SHORT_PAYLOAD;
        end
        else if (view.agent_capture == first_agent_id)
        begin
            status = ST_AGENT_ONE;
        end
        else if (view.agent_capture == second_agent_id)
        begin
            status = ST_AGENT_TWO;
        end
        else
        begin
            status = ST_AGENT_UNKNOWN;
        end
    end

    // Advance the saturating counters
    always_comb
    begin
        first_total_next  = first_total_reg;
        second_total_next = second_total_reg;
        if (status == ST_AGENT_ONE && first_total_reg != COUNT_MAX)
        begin
            first_total_next = first_total_reg + 1'b1;
        end
        if (status == ST_AGENT_TWO && second_total_reg != COUNT_MAX)
        begin
            second_total_next = second_total_reg + 1'b1;
        end
    end

    assign agent_id = (status == ST_AGENT_ONE || status == ST_AGENT_TWO ||
                       status == ST_AGENT_UNKNOWN) ? view.agent_capture : 32'd0;
    assign first_count  = clamp32(first_total_next);
    assign second_count = clamp32(second_total_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_total_reg  <= '0;
            second_total_reg <= '0;
        end
        else if (fire)
        begin
            first_total_reg  <= first_total_next;
            second_total_reg <= second_total_next;
        end
    end

endmodule

[rtl/udp_sample_packet_classifier.sv]
// Classifies captured Ethernet frames carrying sampled-flow UDP datagrams. Frame bytes enter
// on the slave stream in wire order, one per item, with tlast on the final byte; the block
// takes one byte every cycle unless a last byte meets a full output register, and emits one
// result per frame. Bytes pass an input register, then a single stage that captures the
// ethertype, IP header length, protocol, UDP destination port and the 32-bit sub-agent id at
// payload offset 12, and on the last byte checks the frame and loads the output register.
// The result gives the status of the first failing check (short Ethernet, not IPv4, short
// IP, not UDP, short UDP, wrong port, short payload, then agent one, agent two or unknown),
// the sub-agent id when the payload was reached, and the two saturating agent counters.
// Registers: 0 sample_port (reset 6343), 1 first_agent_id (reset 1), 2 second_agent_id
// (reset 2); other indexes are ignored. Write them only while no frame is in progress.
module udp_sample_packet_classifier
    import udp_spc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [3:0] status, [35:4] agent_id,
                                         // [67:36] first_count, [99:68] second_count
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        advance;
    logic        out_free;
    logic        load_out;

    logic         out_valid_reg;
    logic [103:0] out_data_reg;

    logic [15:0] sample_port_reg;
    logic [31:0] first_agent_id_reg;
    logic [31:0] second_agent_id_reg;

    frame_view_t view;
    status_t     status;
    logic [31:0] agent_id;
    logic [31:0] first_count;
    logic [31:0] second_count;

    // Flow control: only a last byte needs room in the output register
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign load_out      = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_port_reg     <= SAMPLE_PORT_RESET;
            first_agent_id_reg  <= FIRST_ID_RESET;
            second_agent_id_reg <= SECOND_ID_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SAMPLE_PORT: sample_port_reg     <= cfg_data[15:0];
                REG_FIRST_ID:    first_agent_id_reg  <= cfg_data;
                REG_SECOND_ID:   second_agent_id_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    udp_spc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .view      (view)
    );

    udp_spc_classify u_classify (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (load_out),
        .view            (view),
        .sample_port     (sample_port_reg),
        .first_agent_id  (first_agent_id_reg),
        .second_agent_id (second_agent_id_reg),
        .status          (status),
        .agent_id        (agent_id),
        .first_count     (first_count),
        .second_count    (second_count)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {4'd0, second_count, first_count, agent_id, status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[sim/udp_spc_verdict_check.sv]
`timescale 1ns / 1ps

// Watches the byte stream, the register writes and the result stream of the
// classifier, predicts every frame verdict and compares it with the block.
module udp_spc_verdict_check
    import udp_spc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,   // [3:0] status, [35:4] agent_id,
                                         // [67:36] first_count, [99:68] second_count
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           err_count,
    output int           pending_count
);

    // Byte offsets of the captured header fields
    localparam int OFS_ETYPE_HI  = 12;
    localparam int OFS_ETYPE_LO  = 13;
    localparam int OFS_IHL       = 14;
    localparam int OFS_PROTO     = 23;
    localparam int OFS_PORT_HI   = 16;   // plus four times the header length
    localparam int OFS_AGENT     = 34;   // plus four times the header length
    localparam int MAX_OFFSET    = 65535;

    // Minimum frame lengths of the staged checks
    localparam int MIN_ETH_LEN   = 14;
    localparam int MIN_IP_LEN    = 34;
    localparam int MIN_UDP_LEN   = 22;   // plus four times the header length
    localparam int MIN_SAMPLE    = 130;  // plus four times the header length

    typedef struct {
        status_t     status;
        logic [31:0] agent;
        logic [31:0] first;
        logic [31:0] second;
    } frame_verdict_t;

    frame_verdict_t expected_verdicts[$];

    // Register copies
    logic [15:0] port_reg;
    logic [31:0] first_id;
    logic [31:0] second_id;

    // Per-frame captures and frame counters
    logic [15:0] offset;
    logic [15:0] ethertype;
    logic [3:0]  hdr_words;
    logic [7:0]  proto;
    logic [15:0] port_cap;
    logic [31:0] agent_cap;
    logic [COUNT_WIDTH-1:0] first_frames;
    logic [COUNT_WIDTH-1:0] second_frames;

    initial
    begin
        err_count     = 0;
        pending_count = 0;
    end

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Show a counter in a 32-bit result field, pinned at all ones
    function automatic logic [31:0] count_field(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        if (w[63:32] != 32'd0)
        begin
            return 32'hFFFF_FFFF;
        end
        return w[31:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (err_count < 10)
        begin
            $display("MISMATCH %s: expected %h, actual %h at %0t ns", what, want, got, $time);
        end
        err_count++;
    endtask

    task automatic clear_frame();
        offset    = '0;
        ethertype = '0;
        hdr_words = '0;
        proto     = '0;
        port_cap  = '0;
        agent_cap = '0;
    endtask

    // Advance the frame by one byte; on the last byte queue the verdict
    task automatic take_byte(input logic [7:0] b, input logic tail);
        int idx;
        int hl4;
        int flen;
        frame_verdict_t v;
        idx = int'(offset);
        hl4 = int'(hdr_words) * 4;
        if (idx == OFS_ETYPE_HI) ethertype[15:8] = b;
        if (idx == OFS_ETYPE_LO) ethertype[7:0] = b;
        if (idx == OFS_IHL) hdr_words = b[3:0];
        if (idx == OFS_PROTO) proto = b;
        if (idx == OFS_PORT_HI + hl4) port_cap[15:8] = b;
        if (idx == OFS_PORT_HI + 1 + hl4) port_cap[7:0] = b;
        if (idx >= OFS_AGENT + hl4 && idx <= OFS_AGENT + 3 + hl4)
        begin
            agent_cap = {agent_cap[23:0], b};
        end
        // Long frames pin the offset at its maximum
        flen = (idx >= MAX_OFFSET) ? MAX_OFFSET : idx + 1;
        offset = 16'(flen);
        if (!tail)
        begin
            return;
        end

        // First failing check decides the status
        hl4 = int'(hdr_words) * 4;
        if (flen < MIN_ETH_LEN) v.status = ST_SHORT_ETH;
        else if (ethertype != ETHERTYPE_IPV4) v.status = ST_NOT_IPV4;
        else if (flen < MIN_IP_LEN) v.status = ST_SHORT_IP;
        else if (proto != PROTO_UDP) v.status = ST_NOT_UDP;
        else if (flen < MIN_UDP_LEN + hl4) v.status = ST_SHORT_UDP;
        else if (port_cap != port_reg) v.status = ST_WRONG_PORT;
        else if (flen < MIN_SAMPLE + hl4) v.status = ST_SHORT_PAYLOAD;
        else if (agent_cap == first_id)
        begin
            // Equal ids: the first counter wins
            v.status = ST_AGENT_ONE;
            first_frames = bump(first_frames);
        end
        else if (agent_cap == second_id)
        begin
            v.status = ST_AGENT_TWO;
            second_frames = bump(second_frames);
        end
        else v.status = ST_AGENT_UNKNOWN;

        v.agent  = (v.status >= ST_AGENT_ONE) ? agent_cap : 32'd0;
        v.first  = count_field(first_frames);
        v.second = count_field(second_frames);
        expected_verdicts.push_back(v);
        clear_frame();
    endtask

    task automatic apply_write(input logic [7:0] idx, input logic [31:0] val);
        if (idx == REG_SAMPLE_PORT) port_reg = val[15:0];
        else if (idx == REG_FIRST_ID) first_id = val;
        else if (idx == REG_SECOND_ID) second_id = val;
    endtask

    // Compare one result item with the oldest expected verdict
    task automatic check_result(input logic [103:0] item);
        frame_verdict_t v;
        if (expected_verdicts.size() == 0)
        begin
            note_mismatch("unexpected result, status", 32'd0, 32'(item[3:0]));
            return;
        end
        v = expected_verdicts.pop_front();
        if (item[3:0] != 4'(v.status)) note_mismatch("status", 32'(v.status), 32'(item[3:0]));
        if (item[35:4] != v.agent) note_mismatch("agent_id", v.agent, item[35:4]);
        if (item[67:36] != v.first) note_mismatch("first_count", v.first, item[67:36]);
        if (item[99:68] != v.second) note_mismatch("second_count", v.second, item[99:68]);
    endtask

    // Sample all channels on the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg      = SAMPLE_PORT_RESET;
            first_id      = FIRST_ID_RESET;
            second_id     = SECOND_ID_RESET;
            first_frames  = '0;
            second_frames = '0;
            clear_frame();
            expected_verdicts.delete();
            pending_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tlast);
            pending_count = expected_verdicts.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import udp_spc_pkg::*;

    localparam int MIN_SAMPLE  = 130;
    localparam int PHASE_BYTES = 413;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] data_byte
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // [3:0] status, [35:4] agent_id,
                                  // [67:36] first_count, [99:68] second_count
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           err_count;
    int           pending_count;

    logic [7:0]   frame_q[$];
    logic [15:0]  cur_port;
    logic [31:0]  cur_first;
    logic [31:0]  cur_second;
    int           bytes_sent;
    int           frames_sent;
    bit           press_go;
    logic         rx_hold;

    udp_sample_packet_classifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    udp_spc_verdict_check verdict_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .err_count     (err_count),
        .pending_count (pending_count)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Overwrite one frame byte if the frame reaches it
    task automatic put_byte(input int at, input logic [7:0] v);
        if (at < frame_q.size()) frame_q[at] = v;
    endtask

    // Fill a frame with random bytes, then place the header fields
    task automatic build_frame(input int len, input logic [15:0] etype, input logic [7:0] vhl,
                               input logic [7:0] proto, input logic [15:0] port,
                               input logic [31:0] agent);
        int i;
        int hl4;
        frame_q.delete();
        for (i = 0; i < len; i++) frame_q.push_back(8'($urandom));
        hl4 = int'(vhl[3:0]) * 4;
        put_byte(12, etype[15:8]);
        put_byte(13, etype[7:0]);
        put_byte(14, vhl);
        put_byte(23, proto);
        put_byte(16 + hl4, port[15:8]);
        put_byte(17 + hl4, port[7:0]);
        put_byte(34 + hl4, agent[31:24]);
        put_byte(35 + hl4, agent[23:16]);
        put_byte(36 + hl4, agent[15:8]);
        put_byte(37 + hl4, agent[7:0]);
    endtask

    // Offer every byte of the frame, with random gaps unless asked not to
    task automatic send_frame(input bit no_gaps);
        int i;
        int gap;
        for (i = 0; i < frame_q.size(); i++)
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= frame_q[i];
            s_axis_tlast  <= (i == frame_q.size() - 1);
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
        end
        bytes_sent  += frame_q.size();
        frames_sent++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Write all three registers; the port write carries junk in its upper half
    task automatic set_config(input logic [15:0] port, input logic [31:0] first,
                              input logic [31:0] second, input bit stray);
        write_reg(REG_SAMPLE_PORT, {16'($urandom), port});
        write_reg(REG_FIRST_ID, first);
        write_reg(REG_SECOND_ID, second);
        if (stray) write_reg(8'($urandom_range(int'(REG_SECOND_ID) + 1, 255)), $urandom);
        cfg_valid <= 1'b0;
        cur_port   = port;
        cur_first  = first;
        cur_second = second;
    endtask

    // Drop the stream and wait until every verdict is back and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One random frame: mostly well formed, the rest at boundaries, broken or noise
    task automatic random_frame();
        int mode;
        int hl;
        int hl4;
        int len;
        int pick;
        logic [31:0] agent;
        logic [7:0]  vhl;
        hl   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
        hl4  = hl * 4;
        vhl  = {4'($urandom), 4'(hl)};
        pick = $urandom_range(0, 3);
        agent = (pick == 1) ? cur_second : (pick == 2) ? 32'($urandom) : cur_first;
        len  = MIN_SAMPLE + hl4 + $urandom_range(0, 24);
        mode = $urandom_range(0, 9);
        case (mode)
            6:
            begin
                // Lengths right at the staged thresholds
                pick = $urandom_range(0, 7);
                case (pick)
                    0: len = 13;
                    1: len = 14;
                    2: len = 33;
                    3: len = 34;
                    4: len = 21 + hl4;
                    5: len = 22 + hl4;
                    6: len = MIN_SAMPLE - 1 + hl4;
                    default: len = MIN_SAMPLE + hl4;
                endcase
                build_frame(len, ETHERTYPE_IPV4, vhl, PROTO_UDP, cur_port, agent);
            end
            7:
            begin
                // One wrong header field
                pick = $urandom_range(0, 2);
                build_frame(len,
                            (pick == 0) ? 16'($urandom) : ETHERTYPE_IPV4, vhl,
                            (pick == 1) ? 8'($urandom) : PROTO_UDP,
                            (pick == 2) ? 16'($urandom) : cur_port, agent);
            end
            8: build_frame($urandom_range(1, 60), ETHERTYPE_IPV4, vhl, PROTO_UDP, cur_port,
                           agent);
            9: build_frame($urandom_range(1, 200), 16'($urandom), 8'($urandom), 8'($urandom),
                           16'($urandom), $urandom);
            default: build_frame(len, ETHERTYPE_IPV4, vhl, PROTO_UDP, cur_port, agent);
        endcase
        send_frame($urandom_range(0, 3) == 0);
    endtask

    // Result side: random hold-offs per item, stretches without, one long stall
    initial
    begin
        int gap;
        int served;
        bit burst;
        m_axis_tready = 1'b0;
        served = 0;
        burst  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (served % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            while (rx_hold)
            begin
                m_axis_tready <= 1'b0;
                @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            served++;
        end
    end

    // Long receiver stall while the sender keeps offering bytes
    initial
    begin
        rx_hold = 1'b0;
        wait (press_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Stop a hung run
    initial
    begin
        #24000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int phase;
        int start_bytes;
        logic [31:0] same_id;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SAMPLE_PORT;
        cfg_data      = 32'd0;
        press_go      = 1'b0;
        bytes_sent    = 0;
        frames_sent   = 0;
        cur_port      = SAMPLE_PORT_RESET;
        cur_first     = FIRST_ID_RESET;
        cur_second    = SECOND_ID_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under reset register values, covering every check stage
        build_frame(1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, 32'd1);
        send_frame(1'b0);
        build_frame(13, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, 32'd1);
        send_frame(1'b0);
        build_frame(14, 16'h86DD, 8'h45, PROTO_UDP, cur_port, 32'd1);
        send_frame(1'b0);
        build_frame(14, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, 32'd1);
        send_frame(1'b0);
        build_frame(33, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, 32'd1);
        send_frame(1'b0);
        build_frame(34, ETHERTYPE_IPV4, 8'h45, 8'd6, cur_port, 32'd1);
        send_frame(1'b0);
        build_frame(34, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, 32'd1);
        send_frame(1'b0);
        build_frame(41, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, 32'd1);
        send_frame(1'b1);
        build_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'd1234, 32'd1);
        send_frame(1'b0);
        build_frame(149, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, 32'd1);
        send_frame(1'b0);
        build_frame(150, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, cur_first);
        send_frame(1'b0);
        build_frame(150, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, cur_second);
        send_frame(1'b1);
        build_frame(150, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, cur_port, 32'hFFFF_FFFF);
        send_frame(1'b0);
        // Header length below five and at its maximum
        build_frame(130, ETHERTYPE_IPV4, 8'h40, PROTO_UDP, cur_port, cur_first);
        send_frame(1'b0);
        build_frame(142, ETHERTYPE_IPV4, 8'h43, PROTO_UDP, cur_port, cur_second);
        send_frame(1'b0);
        build_frame(190, ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, cur_port, cur_first);
        send_frame(1'b0);

        // Extreme settings, equal ids, a write to a missing register
        settle();
        set_config(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        build_frame(150, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'hFFFF, 32'hFFFF_FFFF);
        send_frame(1'b0);
        build_frame(150, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0000, 32'hFFFF_FFFF);
        send_frame(1'b0);
        settle();
        set_config(16'h0000, 32'd0, 32'd0, 1'b0);
        build_frame(150, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0000, 32'd0);
        send_frame(1'b0);

        // Random phases, each under its own settings
        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            same_id = $urandom;
            case (phase)
                0: set_config(16'($urandom), $urandom, $urandom, 1'b1);
                1: set_config(16'h0000, 32'd0, 32'hFFFF_FFFF, 1'b0);
                2: set_config(16'hFFFF, same_id, same_id, 1'b0);
                default: set_config(SAMPLE_PORT_RESET, FIRST_ID_RESET, SECOND_ID_RESET, 1'b1);
            endcase
            if (phase == 1) press_go = 1'b1;
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES)
            begin
                random_frame();
            end
        end

        settle();
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/udp_spc_pkg.sv
rtl/udp_spc_frame.sv
rtl/udp_spc_classify.sv
rtl/udp_sample_packet_classifier.sv
sim/udp_spc_verdict_check.sv
sim/tb_top.sv
